[design/b128c_pkg.sv]
// shared types and constants for the base-128 stream codec
package b128c_pkg;

  localparam int unsigned CountW     = 32;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned PAddrW     = 3;
  localparam int unsigned PDataW     = 32;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadSym   = 2'd1;
  localparam logic [1:0] StatusTrailing = 2'd2;

  // register index taken from the word address bit of paddr
  localparam logic RegModeIdx = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } b128c_in_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        out_byte;
    logic [1:0]        status;
    logic [CountW-1:0] byte_count;
    logic              final_result;
  } b128c_out_t;

  typedef struct packed {
    logic [2:0]        carry_count;
    logic [6:0]        carry_value;
    logic [CountW-1:0] emitted_count;
    logic [1:0]        error_code;
  } b128c_state_t;

endpackage

[design/b128c_step.sv]
// next-state and result-group logic for one word of the codec
module b128c_step (
  input  logic                                          mode_i,
  input  b128c_pkg::b128c_state_t                       state_i,
  input  b128c_pkg::b128c_in_t                          item_i,
  output b128c_pkg::b128c_state_t                       state_o,
  output b128c_pkg::b128c_out_t [b128c_pkg::MaxResults-1:0] res_o,
  output logic [2:0]                                    res_cnt_o
);
  import b128c_pkg::*;

  logic [7:0]  c;
  logic [2:0]  cc;
  logic [6:0]  cv;
  // encode path
  logic        flush_e;
  logic [2:0]  cc_e;
  logic [6:0]  cv_e;
  logic [2:0]  take_e;
  logic [7:0]  mask_e;
  logic [14:0] sh_e;
  logic [6:0]  sym_e;
  logic [6:0]  cv_ne;
  // decode path
  logic [3:0]  take_d;
  logic [8:0]  mask_d;
  logic [14:0] sh_d;
  logic [7:0]  byte_d;
  logic [6:0]  cv_nd;

  logic [2:0][7:0] cand;
  logic [2:0]      cand_v;
  logic [1:0]      nd;
  logic [2:0]      n;
  logic [CountW:0] sum;
  logic [CountW-1:0] cnt_sat;
  b128c_state_t    st;
  logic [1:0]      status;

  always_comb begin
    c  = item_i.data_byte;
    cc = state_i.carry_count;
    cv = state_i.carry_value;

    // a full 7-bit carry goes out as its own symbol first
    flush_e = (cc == 3'd7);
    cc_e    = flush_e ? 3'd0 : cc;
    cv_e    = flush_e ? 7'd0 : cv;
    take_e  = 3'd7 - cc_e;
    mask_e  = (8'd1 << take_e) - 8'd1;
    sh_e    = {7'd0, c & mask_e} << cc_e;
    sym_e   = sh_e[6:0] | cv_e;
    cv_ne   = 7'(c >> take_e);

    take_d  = 4'd8 - {1'b0, cc};
    mask_d  = (9'd1 << take_d) - 9'd1;
    sh_d    = {7'd0, c & mask_d[7:0]} << cc;
    byte_d  = sh_d[7:0] | {1'b0, cv};
    cv_nd   = 7'(c >> take_d);

    st     = state_i;
    cand   = '0;
    cand_v = '0;

    if (mode_i == ModeEncode) begin
      cand[0]   = {1'b0, cv};
      cand_v[0] = flush_e;
      cand[1]   = {1'b0, sym_e};
      cand_v[1] = 1'b1;
      cand[2]   = {1'b0, cv_ne};
      cand_v[2] = item_i.last_byte;
      st.carry_value = cv_ne;
      st.carry_count = cc_e + 3'd1;
    end else if (state_i.error_code == StatusOk) begin
      if (c[7]) begin
        st.error_code = StatusBadSym;
      end else if (cc == 3'd0) begin
        st.carry_count = 3'd7;
        st.carry_value = c[6:0];
      end else begin
        cand[0]   = byte_d;
        cand_v[0] = 1'b1;
        st.carry_value = cv_nd;
        st.carry_count = cc - 3'd1;
      end
    end

    // pack the data words to the front of the group
    res_o = '0;
    nd    = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (cand_v[i]) begin
        res_o[nd].kind     = KindData;
        res_o[nd].out_byte = cand[i];
        nd = nd + 2'd1;
      end
    end

    sum     = {1'b0, state_i.emitted_count} + (CountW+1)'(nd);
    cnt_sat = sum[CountW] ? '1 : sum[CountW-1:0];
    st.emitted_count = cnt_sat;

    status = st.error_code;
    if (status == StatusOk && mode_i == ModeDecode && st.carry_value != 7'd0) begin
      status = StatusTrailing;
    end

    n = {1'b0, nd};
    if (item_i.last_byte) begin
      res_o[nd].kind       = KindEnd;
      res_o[nd].status     = status;
      res_o[nd].byte_count = cnt_sat;
      n  = n + 3'd1;
      st = '0;
    end

    if (n != 3'd0) begin
      res_o[2'(n - 3'd1)].final_result = 1'b1;
    end

    state_o   = st;
    res_cnt_o = n;
  end

endmodule

[design/base128_stream_codec_unit.sv]
// base-128 stream codec top level: input register, codec state, result group drain, apb
//
//   channel | direction | payload          | handshake
//   in      | input     | b128c_in_t       | in_valid_i / in_stall_o
//   out     | output    | b128c_out_t      | out_valid_o / out_stall_i
//   cfg     | apb       | mode at addr 0   | psel / penable, pready always high
//
// an input word is registered, then turns into a group of up to four results held in a
// result register; the group drains one result per cycle while out_stall_i is low. a word
// gives one to four results in encode mode and zero to two in decode mode. the
// next word is taken while the last result of the group is being delivered. reset clears
// state and mode; a stall on the output holds the shown result and backs up into in_stall_o.
module base128_stream_codec_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  b128c_pkg::b128c_in_t               in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output b128c_pkg::b128c_out_t              out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [b128c_pkg::PAddrW-1:0]       paddr,
  input  logic [b128c_pkg::PDataW-1:0]       pwdata,
  output logic [b128c_pkg::PDataW-1:0]       prdata,
  output logic                               pready
);
  import b128c_pkg::*;

  logic                           mode_q;
  logic                           in_vld_q;
  b128c_in_t                      in_q;
  b128c_state_t                   st_q;
  b128c_state_t                   st_d;
  b128c_out_t [MaxResults-1:0]    grp_q;
  b128c_out_t [MaxResults-1:0]    grp_d;
  logic [2:0]                     grp_cnt_q;
  logic [2:0]                     grp_n;
  logic [1:0]                     grp_idx_q;
  logic                           pop;
  logic                           adv;
  logic                           in_acc;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PAddrW-1] == RegModeIdx) ? {{(PDataW-1){1'b0}}, mode_q} : '0;

  assign out_valid_o = (grp_cnt_q != 3'd0);
  assign out_data_o  = grp_q[grp_idx_q];
  assign pop         = out_valid_o && !out_stall_i;
  // a new group loads when the result register is empty or its last word leaves
  assign adv         = in_vld_q && ((grp_cnt_q == 3'd0) || (grp_cnt_q == 3'd1 && pop));
  assign in_stall_o  = in_vld_q && !adv;
  assign in_acc      = in_valid_i && !in_stall_o;

  b128c_step u_step (
    .mode_i    (mode_q),
    .state_i   (st_q),
    .item_i    (in_q),
    .state_o   (st_d),
    .res_o     (grp_d),
    .res_cnt_o (grp_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeEncode;
      in_vld_q  <= 1'b0;
      st_q      <= '0;
      grp_cnt_q <= 3'd0;
      grp_idx_q <= 2'd0;
    end else begin
      if (cfg_wr && paddr[PAddrW-1] == RegModeIdx) begin
        mode_q <= pwdata[0];
      end
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        st_q      <= st_d;
        grp_cnt_q <= grp_n;
        grp_idx_q <= 2'd0;
      end else if (pop) begin
        grp_cnt_q <= grp_cnt_q - 3'd1;
        grp_idx_q <= grp_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      grp_q <= grp_d;
    end
  end

`ifndef SYNTHESIS
  a_grp_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_cnt_q <= 3'(MaxResults))
    else $error("result group count out of range");

  a_final_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.final_result |-> grp_cnt_q == 3'd1)
    else $error("final flag shown before the last result of a group");

  a_end_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindEnd |-> out_data_o.final_result)
    else $error("end result not marked final");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindData |->
      out_data_o.status == StatusOk && out_data_o.byte_count == '0)
    else $error("data result carries status or count");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.last_byte |=> st_q.carry_count == 3'd0 && st_q.emitted_count == '0
      && st_q.error_code == StatusOk)
    else $error("state not cleared after end of message");
`endif

endmodule

[sim/b128c_checker.sv]
// result checker for the base-128 stream codec: tracks mode, works out results, compares
`timescale 1ns / 100ps
module b128c_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  b128c_pkg::b128c_in_t             in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  b128c_pkg::b128c_out_t            out_data_i,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic                             pready_i,
  input  logic [b128c_pkg::PAddrW-1:0]     paddr_i,
  input  logic [b128c_pkg::PDataW-1:0]     pwdata_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import b128c_pkg::*;

  logic              mode_q    = ModeEncode;
  logic [2:0]        carry_cnt = '0;
  logic [6:0]        carry_val = '0;
  logic [CountW-1:0] emitted   = '0;
  logic [1:0]        err_code  = StatusOk;
  b128c_out_t        coded_q[$];
  int                fails     = 0;

  function automatic string fmt_result(input b128c_out_t r);
    return $sformatf("kind=%0d byte=%02h status=%0d count=%0d final=%0d",
                     r.kind, r.out_byte, r.status, r.byte_count, r.final_result);
  endfunction

  task automatic add_result(input logic k, input logic [7:0] b, input logic [1:0] st,
                            input logic [CountW-1:0] cnt);
    b128c_out_t r;
    r.kind         = k;
    r.out_byte     = b;
    r.status       = st;
    r.byte_count   = cnt;
    r.final_result = 1'b0;
    coded_q.push_back(r);
  endtask

  task automatic add_symbol(input logic [7:0] b);
    add_result(KindData, b, StatusOk, '0);
    if (emitted != '1) emitted = emitted + 1'b1;
  endtask

  task automatic clear_message();
    carry_cnt = '0;
    carry_val = '0;
    emitted   = '0;
    err_code  = StatusOk;
  endtask

  // all results caused by one accepted input word
  task automatic code_word(input b128c_in_t w);
    int unsigned c;
    int unsigned take;
    int unsigned v;
    int          n0;
    logic [1:0]  st;
    b128c_out_t  r;
    c  = w.data_byte;
    n0 = coded_q.size();
    if (mode_q == ModeEncode) begin
      // a full 7-bit carry goes out on its own first
      if (carry_cnt == 3'd7) begin
        add_symbol({1'b0, carry_val});
        carry_cnt = '0;
        carry_val = '0;
      end
      take = 7 - carry_cnt;
      v = (((c & ((1 << take) - 1)) << carry_cnt) | carry_val) & 'h7f;
      add_symbol(v[7:0]);
      carry_val = 7'((c >> take) & 'h7f);
      carry_cnt = carry_cnt + 3'd1;
      if (w.last_byte && carry_cnt != 3'd0) add_symbol({1'b0, carry_val});
    end else if (err_code == StatusOk) begin
      if (w.data_byte[7]) begin
        err_code = StatusBadSym;
      end else if (carry_cnt == 3'd0) begin
        carry_cnt = 3'd7;
        carry_val = w.data_byte[6:0];
      end else begin
        take = 8 - carry_cnt;
        v = (carry_val | ((c & ((1 << take) - 1)) << carry_cnt)) & 'hff;
        add_symbol(v[7:0]);
        carry_val = 7'((c >> take) & 'h7f);
        carry_cnt = carry_cnt - 3'd1;
      end
    end
    if (w.last_byte) begin
      st = err_code;
      if (st == StatusOk && mode_q == ModeDecode && carry_val != '0) st = StatusTrailing;
      add_result(KindEnd, 8'h00, st, emitted);
      clear_message();
    end
    if (coded_q.size() > n0) begin
      r = coded_q.pop_back();
      r.final_result = 1'b1;
      coded_q.push_back(r);
    end
  endtask

  task automatic check_result(input b128c_out_t got);
    b128c_out_t want;
    if (coded_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("checker: unexpected result %s", fmt_result(got));
    end else begin
      want = coded_q.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.status !== want.status || got.byte_count !== want.byte_count ||
          got.final_result !== want.final_result) begin
        fails++;
        if (fails <= 10) begin
          $display("checker: mismatch, expected %s, got %s", fmt_result(want), fmt_result(got));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = ModeEncode;
      clear_message();
      coded_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) code_word(in_data_i);
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[PAddrW-1:2] == RegModeIdx) begin
        mode_q = pwdata_i[0];
      end
      pending_o    <= coded_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

[sim/testbench.sv]
// top of the base-128 stream codec test: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 100ps
module testbench;
  import b128c_pkg::*;

  localparam int IdleLimit = 1000;
  localparam int HoldLen   = 60;
  localparam int WordGoal  = 360;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  b128c_in_t         in_word   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  b128c_out_t        out_word;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PAddrW-1:0] paddr     = '0;
  logic [PDataW-1:0] pwdata    = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int quiet    = 0;
  bit tx_calm  = 1'b0;
  bit rx_calm  = 1'b0;
  bit hold_req = 1'b0;

  logic [7:0] enc_seed[8] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h55, 8'haa, 8'h01, 8'hfe};
  logic [7:0] dec_seed[8] = '{8'h7f, 8'h00, 8'h55, 8'h2a, 8'h01, 8'h7e, 8'h40, 8'h3f};

  always #1 clk = ~clk;

  base128_stream_codec_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  b128c_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_word),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // nothing accepted on either channel for too long ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall before each word, one long hold on request
  initial begin : receiver
    int n;
    forever begin
      if (hold_req) begin
        n = HoldLen;
        hold_req = 1'b0;
      end else if (rx_calm) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 5);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_word(input logic [7:0] value, input logic ends);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: value, last_byte: ends};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait until every result is back, then give the block time to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAddrW'({RegModeIdx, 2'b00});
    pwdata  <= PDataW'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // decode mode mostly gets clean 7-bit symbols, now and then a bad one
  function automatic logic [7:0] pick_byte(input logic m);
    if (m == ModeEncode) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  initial begin : stimulus
    int   words;
    int   phases;
    int   n_msgs;
    int   len;
    bit   open_end;
    logic m;
    words  = 0;
    phases = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode: a carry fills up to a full symbol, then a lone byte flushes
    write_mode(ModeEncode);
    foreach (enc_seed[i]) send_word(enc_seed[i], i == 7);
    send_word(8'hff, 1'b1);
    settle();

    // decode: eight symbols end clean, then a bad symbol left open across a mode change
    write_mode(ModeDecode);
    foreach (dec_seed[i]) send_word(dec_seed[i], i == 7);
    send_word(8'h12, 1'b0);
    send_word(8'h80, 1'b0);
    settle();
    write_mode(ModeEncode);
    send_word(8'ha5, 1'b1);
    settle();
    write_mode(ModeDecode);
    send_word(8'h7f, 1'b1);
    send_word(8'h00, 1'b1);

    while (words < WordGoal) begin
      settle();
      m = logic'($urandom_range(0, 1));
      write_mode(m);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phases == 3) hold_req = 1'b1;
      n_msgs = $urandom_range(2, 5);
      for (int k = 0; k < n_msgs; k++) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        // multiples of eight symbols let a decode end with no leftover bits
        len = ($urandom_range(0, 4) == 0) ? 8 * $urandom_range(1, 2) : $urandom_range(1, 12);
        open_end = (k == n_msgs - 1) && ($urandom_range(0, 5) == 0);
        for (int j = 0; j < len; j++) begin
          send_word(pick_byte(m), (j == len - 1) && !open_end);
          words++;
        end
      end
      phases++;
    end

    // close any message left open
    send_word(8'h00, 1'b1);
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
design/b128c_pkg.sv
design/b128c_step.sv
design/base128_stream_codec_unit.sv
sim/b128c_checker.sv
sim/testbench.sv
